/* hw/rtl/cet_pkg.sv */
// Shared types, constants and saturating helpers for the Chebyshev escape-time core.
// No dependencies; every other file refers to this package by scoped names.
package cet_pkg;

  localparam int FixW    = 48;  // Q24.24 working format
  localparam int FracW   = 24;
  localparam int InW     = 32;  // Q4.28 input format
  localparam int IterW   = 12;
  localparam int BailW   = 16;
  localparam int DegCfgW = 4;
  localparam int MagW    = 32;
  localparam int LimPadW = FixW - BailW - FracW;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgMaxIter = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBailout = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDegree  = 2'd2;

  localparam logic [IterW-1:0]   MaxIterRst = 12'd256;
  localparam logic [BailW-1:0]   BailoutRst = 16'd1000;
  localparam logic [DegCfgW-1:0] DegreeRst  = 4'd4;

  typedef logic signed [FixW-1:0] fix_t;

  localparam fix_t FixOne = 48'sh0000_0100_0000;
  localparam fix_t FixMax = 48'sh7FFF_FFFF_FFFF;
  localparam fix_t FixMin = 48'sh8000_0000_0000;

  typedef struct packed {
    logic signed [InW-1:0] c_real;
    logic signed [InW-1:0] c_imag;
  } in_item_t;

  typedef struct packed {
    logic [IterW-1:0] iteration_count;
    logic             escaped;
    logic [MagW-1:0]  final_mag_sq;
  } out_item_t;

  // Point after conversion to the working format
  typedef struct packed {
    fix_t c_re;
    fix_t c_im;
  } pt_t;

  typedef struct packed {
    logic [IterW-1:0] max_iterations;
    logic [BailW-1:0] bailout_sq;
  } cfg_t;

  function automatic fix_t sat_sum(logic signed [FixW:0] s);
    fix_t r;
    if (s[FixW] != s[FixW-1]) begin
      r = s[FixW] ? FixMin : FixMax;
    end else begin
      r = s[FixW-1:0];
    end
    return r;
  endfunction

  function automatic fix_t fx_add(fix_t a, fix_t b);
    logic signed [FixW:0] s;
    s = (FixW+1)'(a) + (FixW+1)'(b);
    return sat_sum(s);
  endfunction

  function automatic fix_t fx_sub(fix_t a, fix_t b);
    logic signed [FixW:0] s;
    s = (FixW+1)'(a) - (FixW+1)'(b);
    return sat_sum(s);
  endfunction

endpackage

/* hw/rtl/cet_front.sv */
// Front end: configuration registers, input conversion to Q24.24 and a short point queue.
// Depends on cet_pkg.
module cet_front #(
  parameter int MAX_DEGREE = 8,
  parameter int DegW       = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cet_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cet_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cet_pkg::in_item_t             in_item_i,
  output cet_pkg::cfg_t                 cfg_o,
  output logic [DegW-1:0]               deg_o,
  output logic                          pt_valid_o,
  input  logic                          pt_ready_i,
  output cet_pkg::pt_t                  pt_o
);

  localparam int QDepth = 2;  // power of two so the pointers wrap by themselves
  localparam int QPtrW  = $clog2(QDepth);
  localparam int PadW   = cet_pkg::FixW - (cet_pkg::InW - 4);

  logic [cet_pkg::IterW-1:0]   max_iter_q;
  logic [cet_pkg::BailW-1:0]   bailout_q;
  logic [cet_pkg::DegCfgW-1:0] degree_q;

  cet_pkg::pt_t     q_mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   cnt_q, cnt_d;
  logic             push, pop;
  cet_pkg::pt_t     pt_conv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= cet_pkg::MaxIterRst;
      bailout_q  <= cet_pkg::BailoutRst;
      degree_q   <= cet_pkg::DegreeRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cet_pkg::CfgMaxIter: max_iter_q <= cfg_data_i[cet_pkg::IterW-1:0];
        cet_pkg::CfgBailout: bailout_q  <= cfg_data_i[cet_pkg::BailW-1:0];
        cet_pkg::CfgDegree:  degree_q   <= cfg_data_i[cet_pkg::DegCfgW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.max_iterations = max_iter_q;
  assign cfg_o.bailout_sq     = bailout_q;

  // Clamp the degree to what the recurrence supports
  always_comb begin
    if (32'(degree_q) > MAX_DEGREE) begin
      deg_o = DegW'(MAX_DEGREE);
    end else begin
      deg_o = DegW'(degree_q);
    end
  end

  // Q4.28 to Q24.24: arithmetic shift right by four
  assign pt_conv.c_re = {{PadW{in_item_i.c_real[cet_pkg::InW-1]}},
                         in_item_i.c_real[cet_pkg::InW-1:4]};
  assign pt_conv.c_im = {{PadW{in_item_i.c_imag[cet_pkg::InW-1]}},
                         in_item_i.c_imag[cet_pkg::InW-1:4]};

  assign in_ready_o = (cnt_q < (QPtrW+1)'(QDepth));
  assign pt_valid_o = (cnt_q != '0);
  assign pt_o       = q_mem_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = pt_valid_o && pt_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= pt_conv;
    end
  end

endmodule

/* hw/rtl/cet_fxmul.sv */
// Sequential Q24.24 multiplier: one 24x24 partial product per cycle, saturating result.
// Depends on cet_pkg.
module cet_fxmul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  cet_pkg::fix_t a_i,
  input  cet_pkg::fix_t b_i,
  output logic          done_o,
  output cet_pkg::fix_t p_o
);

  localparam int HalfW = cet_pkg::FracW;
  localparam int ProdW = 2 * HalfW;
  localparam int AccW  = ProdW + 3;

  localparam logic [2:0] StepHh  = 3'd0;
  localparam logic [2:0] StepHl  = 3'd1;
  localparam logic [2:0] StepLh  = 3'd2;
  localparam logic [2:0] StepLl  = 3'd3;
  localparam logic [2:0] StepLow = 3'd4;
  localparam logic [2:0] StepFin = 3'd5;

  logic             busy_q;
  logic [2:0]       step_q;
  logic             done_q;
  logic [HalfW-1:0] ah_q, al_q, bh_q, bl_q;
  logic             neg_q;
  logic             big_q;
  logic [ProdW-1:0] prod_q;
  logic [AccW-1:0]  acc_q;
  cet_pkg::fix_t    p_q;

  logic [ProdW-1:0] ma, mb;
  logic [HalfW-1:0] op_a, op_b;
  logic [ProdW-1:0] prod_d;
  logic [ProdW:0]   mag;
  logic signed [cet_pkg::FixW-1:0] mag_s;
  cet_pkg::fix_t    res;

  assign ma = a_i[cet_pkg::FixW-1] ? ProdW'(-a_i) : ProdW'(a_i);
  assign mb = b_i[cet_pkg::FixW-1] ? ProdW'(-b_i) : ProdW'(b_i);

  always_comb begin
    case (step_q)
      StepHh:  begin op_a = ah_q; op_b = bh_q; end
      StepHl:  begin op_a = ah_q; op_b = bl_q; end
      StepLh:  begin op_a = al_q; op_b = bh_q; end
      default: begin op_a = al_q; op_b = bl_q; end
    endcase
    prod_d = ProdW'(op_a) * ProdW'(op_b);
  end

  // Clamp the magnitude to 2^48, then apply the sign and saturate
  always_comb begin
    if (big_q || acc_q > (AccW'(1) << ProdW)) begin
      mag = (ProdW+1)'(1) << ProdW;
    end else begin
      mag = acc_q[ProdW:0];
    end
    mag_s = {1'b0, mag[ProdW-2:0]};
    if (mag[ProdW] || mag[ProdW-1]) begin
      res = neg_q ? cet_pkg::FixMin : cet_pkg::FixMax;
    end else begin
      res = neg_q ? -mag_s : mag_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= StepHh;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (step_q == StepFin);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepHh;
      end else if (busy_q) begin
        if (step_q == StepFin) begin
          busy_q <= 1'b0;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ah_q  <= ma[ProdW-1:HalfW];
      al_q  <= ma[HalfW-1:0];
      bh_q  <= mb[ProdW-1:HalfW];
      bl_q  <= mb[HalfW-1:0];
      neg_q <= a_i[cet_pkg::FixW-1] != b_i[cet_pkg::FixW-1];
    end else if (busy_q) begin
      case (step_q)
        StepHh: prod_q <= prod_d;
        StepHl: begin
          big_q  <= |prod_q[ProdW-1:HalfW-1];
          acc_q  <= {prod_q[AccW-HalfW-1:0], {HalfW{1'b0}}};
          prod_q <= prod_d;
        end
        StepLh: begin
          acc_q  <= acc_q + AccW'(prod_q);
          prod_q <= prod_d;
        end
        StepLl: begin
          acc_q  <= acc_q + AccW'(prod_q);
          prod_q <= prod_d;
        end
        StepLow: acc_q <= acc_q + AccW'(prod_q[ProdW-1:HalfW]);
        StepFin: p_q <= res;
        default: ;
      endcase
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

/* hw/rtl/cet_back.sv */
// Back end: escape-time iteration sequencer, Chebyshev recurrence and result register.
// Depends on cet_pkg and cet_fxmul.
module cet_back #(
  parameter int DegW = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cet_pkg::cfg_t      cfg_i,
  input  logic [DegW-1:0]    deg_i,
  input  logic               pt_valid_i,
  output logic               pt_ready_o,
  input  cet_pkg::pt_t       pt_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cet_pkg::out_item_t out_item_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StCheck = 4'd1;
  localparam logic [3:0] StSqRe  = 4'd2;
  localparam logic [3:0] StSqIm  = 4'd3;
  localparam logic [3:0] StCmp   = 4'd4;
  localparam logic [3:0] StPa    = 4'd5;
  localparam logic [3:0] StPb    = 4'd6;
  localparam logic [3:0] StPc    = 4'd7;
  localparam logic [3:0] StPd    = 4'd8;
  localparam logic [3:0] StPe    = 4'd9;
  localparam logic [3:0] StDbl   = 4'd10;
  localparam logic [3:0] StComb  = 4'd11;
  localparam logic [3:0] StZUpd  = 4'd12;
  localparam logic [3:0] StFin   = 4'd13;

  logic [3:0] state_q, state_d;
  logic [cet_pkg::IterW-1:0] iter_q, iter_d;
  logic       out_valid_q, out_valid_d;
  cet_pkg::out_item_t out_item_q;

  cet_pkg::fix_t c_re_q, c_im_q, zr_q, zi_q, t0_q, t1_q;
  cet_pkg::fix_t pr_q, pi_q, cr_q, ci_q, mag_q;
  logic          esc_q;
  logic [DegW-1:0] k_q;

  logic          mul_start, mul_done;
  cet_pkg::fix_t mul_a, mul_b, mul_p;

  logic          at_limit, over, deg_lin, recur_more, out_free;
  logic [DegW:0] k_inc;
  logic [cet_pkg::FixW-1:0] limit;

  cet_fxmul u_fxmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign limit      = {{cet_pkg::LimPadW{1'b0}}, cfg_i.bailout_sq, {cet_pkg::FracW{1'b0}}};
  assign at_limit   = (iter_q == cfg_i.max_iterations);
  assign over       = ($unsigned(mag_q) > limit);
  assign deg_lin    = (deg_i == '0) || (deg_i == DegW'(1));
  assign k_inc      = {1'b0, k_q} + 1'b1;
  assign recur_more = (k_inc < {1'b0, deg_i});
  assign out_free   = !out_valid_q || out_ready_i;
  assign pt_ready_o = (state_q == StIdle);

  // Multiplier issue: square terms for the check, four products per recurrence step
  always_comb begin
    mul_start = 1'b0;
    mul_a     = zr_q;
    mul_b     = zr_q;
    case (state_q)
      StCheck: mul_start = !at_limit;
      StSqRe: begin
        mul_start = mul_done;
        mul_a     = zi_q;
        mul_b     = zi_q;
      end
      StPa: begin
        mul_start = 1'b1;
        mul_b     = cr_q;
      end
      StPb: begin
        mul_start = mul_done;
        mul_a     = zi_q;
        mul_b     = ci_q;
      end
      StPc: begin
        mul_start = mul_done;
        mul_b     = ci_q;
      end
      StPd: begin
        mul_start = mul_done;
        mul_a     = zi_q;
        mul_b     = cr_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    iter_d      = iter_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        if (pt_valid_i) begin
          state_d = StCheck;
          iter_d  = '0;
        end
      end
      StCheck: state_d = at_limit ? StFin : StSqRe;
      StSqRe:  if (mul_done) state_d = StSqIm;
      StSqIm:  if (mul_done) state_d = StCmp;
      StCmp: begin
        if (over) begin
          state_d = StFin;
        end else if (deg_lin) begin
          state_d = StCheck;
          iter_d  = iter_q + 1'b1;
        end else begin
          state_d = StPa;
        end
      end
      StPa:    state_d = StPb;
      StPb:    if (mul_done) state_d = StPc;
      StPc:    if (mul_done) state_d = StPd;
      StPd:    if (mul_done) state_d = StPe;
      StPe:    if (mul_done) state_d = StDbl;
      StDbl:   state_d = StComb;
      StComb:  state_d = recur_more ? StPa : StZUpd;
      StZUpd: begin
        state_d = StCheck;
        iter_d  = iter_q + 1'b1;
      end
      StFin: begin
        // hold the finished point until the result register frees up
        if (out_free) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (pt_valid_i) begin
          c_re_q <= pt_i.c_re;
          c_im_q <= pt_i.c_im;
          zr_q   <= '0;
          zi_q   <= '0;
        end
      end
      StCheck: esc_q <= 1'b0;
      StSqRe:  if (mul_done) t0_q <= mul_p;
      StSqIm:  if (mul_done) mag_q <= cet_pkg::fx_add(t0_q, mul_p);
      StCmp: begin
        if (over) begin
          esc_q <= 1'b1;
        end else if (deg_i == '0) begin
          zr_q <= cet_pkg::fx_add(cet_pkg::FixOne, c_re_q);
          zi_q <= c_im_q;
        end else if (deg_i == DegW'(1)) begin
          zr_q <= cet_pkg::fx_add(zr_q, c_re_q);
          zi_q <= cet_pkg::fx_add(zi_q, c_im_q);
        end else begin
          pr_q <= cet_pkg::FixOne;
          pi_q <= '0;
          cr_q <= zr_q;
          ci_q <= zi_q;
          k_q  <= DegW'(1);
        end
      end
      StPb: if (mul_done) t0_q <= mul_p;
      StPc: if (mul_done) t0_q <= cet_pkg::fx_sub(t0_q, mul_p);
      StPd: if (mul_done) t1_q <= mul_p;
      StPe: if (mul_done) t1_q <= cet_pkg::fx_add(t1_q, mul_p);
      StDbl: begin
        t0_q <= cet_pkg::fx_add(t0_q, t0_q);
        t1_q <= cet_pkg::fx_add(t1_q, t1_q);
      end
      StComb: begin
        cr_q <= cet_pkg::fx_sub(t0_q, pr_q);
        ci_q <= cet_pkg::fx_sub(t1_q, pi_q);
        pr_q <= cr_q;
        pi_q <= ci_q;
        k_q  <= k_inc[DegW-1:0];
      end
      StZUpd: begin
        zr_q <= cet_pkg::fx_add(cr_q, c_re_q);
        zi_q <= cet_pkg::fx_add(ci_q, c_im_q);
      end
      StFin: begin
        if (out_free) begin
          out_item_q.iteration_count <= iter_q;
          out_item_q.escaped         <= esc_q;
          if (!esc_q) begin
            out_item_q.final_mag_sq <= '0;
          end else if (|mag_q[cet_pkg::FixW-1:cet_pkg::MagW+8]) begin
            out_item_q.final_mag_sq <= '1;
          end else begin
            out_item_q.final_mag_sq <= mag_q[cet_pkg::MagW+7:8];
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* hw/rtl/chebyshev_escape_time_core.sv */
// Chebyshev escape-time core: iterates z = T_degree(z) + c per point in Q24.24.
// Depends on cet_pkg, cet_front, cet_back (which holds cet_fxmul).
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_item_i) takes one point c in Q4.28.
//   Output channel (out_valid_o/out_ready_i/out_item_o) gives one result per point,
//   in order: escape iteration, escaped flag and |z|^2 in Q16.16.
//   Configuration channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i) is always
//   ready; write it only while no point is in flight. Unknown indexes are dropped.
// Timing:
//   Points are evaluated one at a time. Each product goes through one shared
//   multiplier that builds it from four 24x24 partial products. Every iteration needs
//   two square products, and degree 2 or more adds four products per recurrence step.
//   A two-entry queue ahead of the iteration engine keeps accepting points while
//   one is evaluated; a finished result waits in the output register.
// Reset: clears the queue and output valid, restores max_iterations 256,
//   bailout 1000 and degree 4. A stalled receiver holds the result and, once the
//   queue is full, in_ready_o drops.
module chebyshev_escape_time_core #(
  parameter int MAX_DEGREE = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cet_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cet_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cet_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cet_pkg::out_item_t            out_item_o
);

  localparam int DegW = $clog2(MAX_DEGREE + 1);

  cet_pkg::cfg_t   cfg;
  logic [DegW-1:0] deg;
  logic            pt_valid, pt_ready;
  cet_pkg::pt_t    pt;

  cet_front #(
    .MAX_DEGREE (MAX_DEGREE),
    .DegW       (DegW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cfg_o       (cfg),
    .deg_o       (deg),
    .pt_valid_o  (pt_valid),
    .pt_ready_i  (pt_ready),
    .pt_o        (pt)
  );

  cet_back #(
    .DegW (DegW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .deg_i       (deg),
    .pt_valid_i  (pt_valid),
    .pt_ready_o  (pt_ready),
    .pt_i        (pt),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* bench/tb.sv */
// Self-checking bench for the Chebyshev escape-time core: directed and random points
// checked against an in-bench fixed-point evaluator. Needs cet_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

  localparam int MaxDegree = 8;
  localparam int WatchLimit = 500000;
  localparam int PhaseItems = 70;
  localparam logic [cet_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic [cet_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [cet_pkg::CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  cet_pkg::in_item_t in_item = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  cet_pkg::out_item_t out_item_o;

  // Bench copy of the core's registers
  logic [cet_pkg::IterW-1:0] cur_max_iter = cet_pkg::MaxIterRst;
  logic [cet_pkg::BailW-1:0] cur_bailout = cet_pkg::BailoutRst;
  logic [cet_pkg::DegCfgW-1:0] cur_degree = cet_pkg::DegreeRst;

  cet_pkg::out_item_t pending_results[$];
  cet_pkg::out_item_t want;
  int errors = 0;
  int idle_cycles = 0;
  logic steady = 1'b0;

  chebyshev_escape_time_core #(
    .MAX_DEGREE(MaxDegree)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_item_o (out_item_o)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------- evaluator

  function automatic cet_pkg::fix_t clamp_fix(logic signed [cet_pkg::FixW+1:0] s);
    if (s > cet_pkg::FixMax) return cet_pkg::FixMax;
    if (s < cet_pkg::FixMin) return cet_pkg::FixMin;
    return s[cet_pkg::FixW-1:0];
  endfunction

  function automatic cet_pkg::fix_t sat_add(cet_pkg::fix_t a, cet_pkg::fix_t b);
    logic signed [cet_pkg::FixW+1:0] s;
    s = (cet_pkg::FixW+2)'(a) + (cet_pkg::FixW+2)'(b);
    return clamp_fix(s);
  endfunction

  function automatic cet_pkg::fix_t sat_sub(cet_pkg::fix_t a, cet_pkg::fix_t b);
    logic signed [cet_pkg::FixW+1:0] s;
    s = (cet_pkg::FixW+2)'(a) - (cet_pkg::FixW+2)'(b);
    return clamp_fix(s);
  endfunction

  // Q24.24 product, magnitude truncated, then saturated
  function automatic cet_pkg::fix_t sat_mul(cet_pkg::fix_t a, cet_pkg::fix_t b);
    logic [cet_pkg::FixW-1:0] ma, mb;
    logic [2*cet_pkg::FixW-1:0] prod;
    logic [2*cet_pkg::FixW-cet_pkg::FracW-1:0] mag;
    logic neg;
    cet_pkg::fix_t t;
    neg = a[cet_pkg::FixW-1] ^ b[cet_pkg::FixW-1];
    ma = a[cet_pkg::FixW-1] ? -a : a;
    mb = b[cet_pkg::FixW-1] ? -b : b;
    prod = (2*cet_pkg::FixW)'(ma) * (2*cet_pkg::FixW)'(mb);
    mag = prod[2*cet_pkg::FixW-1:cet_pkg::FracW];
    if (!neg) begin
      if (mag > 72'h7FFF_FFFF_FFFF) return cet_pkg::FixMax;
      t = mag[cet_pkg::FixW-1:0];
      return t;
    end
    if (mag >= 72'h8000_0000_0000) return cet_pkg::FixMin;
    t = mag[cet_pkg::FixW-1:0];
    return -t;
  endfunction

  function automatic cet_pkg::fix_t to_fix(logic signed [cet_pkg::InW-1:0] x);
    cet_pkg::fix_t v;
    v = cet_pkg::FixW'(x);
    return v >>> 4;
  endfunction

  function automatic cet_pkg::out_item_t eval_point(cet_pkg::in_item_t pt);
    cet_pkg::fix_t cr, ci, zr, zi, pr, pi, qr, qi, nr, ni, sq, limit;
    int unsigned deg, it;
    logic esc;
    logic [39:0] fm;
    cet_pkg::out_item_t res;
    cr = to_fix(pt.c_real);
    ci = to_fix(pt.c_imag);
    limit = {{cet_pkg::LimPadW{1'b0}}, cur_bailout, 24'h0};
    deg = (cur_degree > MaxDegree) ? MaxDegree : cur_degree;
    zr = '0;
    zi = '0;
    sq = '0;
    esc = 1'b0;
    it = 0;
    while (it < cur_max_iter && !esc) begin
      sq = sat_add(sat_mul(zr, zr), sat_mul(zi, zi));
      if (sq > limit) begin
        esc = 1'b1;
      end else begin
        if (deg == 0) begin
          zr = sat_add(cet_pkg::FixOne, cr);
          zi = ci;
        end else if (deg == 1) begin
          zr = sat_add(zr, cr);
          zi = sat_add(zi, ci);
        end else begin
          pr = cet_pkg::FixOne;
          pi = '0;
          qr = zr;
          qi = zi;
          for (int k = 1; k < deg; k++) begin
            nr = sat_sub(sat_mul(zr, qr), sat_mul(zi, qi));
            ni = sat_add(sat_mul(zr, qi), sat_mul(zi, qr));
            nr = sat_sub(sat_add(nr, nr), pr);
            ni = sat_sub(sat_add(ni, ni), pi);
            pr = qr;
            pi = qi;
            qr = nr;
            qi = ni;
          end
          zr = sat_add(qr, cr);
          zi = sat_add(qi, ci);
        end
        it++;
      end
    end
    fm = sq[cet_pkg::FixW-1:8];
    res.iteration_count = it[cet_pkg::IterW-1:0];
    res.escaped = esc;
    res.final_mag_sq = !esc ? '0 : (fm[39:32] != 0) ? 32'hFFFF_FFFF : fm[31:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cet_pkg::in_item_t rand_point();
    cet_pkg::in_item_t p;
    logic signed [cet_pkg::InW-1:0] re, im;
    int unsigned k;
    re = $urandom;
    im = $urandom;
    // narrow most points toward the interesting region around the origin
    k = $urandom_range(0, 4);
    p.c_real = re >>> k;
    p.c_imag = im >>> k;
    return p;
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_point(input cet_pkg::in_item_t pt);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= pt;
    do @(posedge clk); while (!in_ready_o);
    pending_results.push_back(eval_point(pt));
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [cet_pkg::CfgIdxW-1:0] idx,
                           input logic [cet_pkg::CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      cet_pkg::CfgMaxIter: cur_max_iter = data[cet_pkg::IterW-1:0];
      cet_pkg::CfgBailout: cur_bailout = data[cet_pkg::BailW-1:0];
      cet_pkg::CfgDegree:  cur_degree = data[cet_pkg::DegCfgW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [cet_pkg::CfgDataW-1:0] iter_data,
                            input logic [cet_pkg::CfgDataW-1:0] bail_data,
                            input logic [cet_pkg::CfgDataW-1:0] deg_data);
    write_reg(cet_pkg::CfgMaxIter, iter_data);
    write_reg(cet_pkg::CfgBailout, bail_data);
    write_reg(cet_pkg::CfgDegree, deg_data);
  endtask

  // Drop valid and hold until every point has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic cet_pkg::in_item_t mk_point(logic signed [cet_pkg::InW-1:0] re,
                                                 logic signed [cet_pkg::InW-1:0] im);
    cet_pkg::in_item_t p;
    p.c_real = re;
    p.c_imag = im;
    return p;
  endfunction

  // ---------------------------------------------------------------- receiver

  initial begin : ready_pattern
    int unsigned run_len, stall_len;
    @(negedge clk);
    forever begin
      run_len = $urandom_range(1, 12);
      stall_len = pick_gap();
      out_ready <= 1'b1;
      repeat (run_len) @(negedge clk);
      if (stall_len != 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no point pending: count %0d", out_item_o.iteration_count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.iteration_count !== want.iteration_count) begin
          $error("iteration_count: expected %0d, got %0d", want.iteration_count,
                 out_item_o.iteration_count);
          errors++;
        end
        if (out_item_o.escaped !== want.escaped) begin
          $error("escaped: expected %0b, got %0b", want.escaped, out_item_o.escaped);
          errors++;
        end
        if (out_item_o.final_mag_sq !== want.final_mag_sq) begin
          $error("final_mag_sq: expected 0x%08h, got 0x%08h", want.final_mag_sq,
                 out_item_o.final_mag_sq);
          errors++;
        end
      end
    end
  end

  // Count cycles with no item moving on any channel.
  always @(posedge clk) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    send_point(mk_point(32'sh0, 32'sh0));
    send_point(mk_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_point(mk_point(32'sh8000_0000, 32'sh8000_0000));
    send_point(mk_point(32'sh7FFF_FFFF, 32'sh8000_0000));
    wait_idle();
  endtask

  task automatic test_degree_sweep();
    int unsigned degs[8] = '{0, 1, 2, 3, 5, 8, 12, 15};
    logic [cet_pkg::CfgDataW-1:0] d;
    write_reg(cet_pkg::CfgMaxIter, 16'd6);
    write_reg(cet_pkg::CfgBailout, 16'd4);
    for (int i = 0; i < 8; i++) begin
      d = cet_pkg::CfgDataW'($urandom);
      d[cet_pkg::DegCfgW-1:0] = cet_pkg::DegCfgW'(degs[i]);
      write_reg(cet_pkg::CfgDegree, d);
      if (i % 2 == 0) send_point(mk_point(32'sh0800_0000, 32'sh0400_0000));
      else send_point(mk_point(32'shEC00_0000, 32'sh0C00_0000));
      wait_idle();
    end
  endtask

  task automatic test_zero_bailout();
    set_config(16'd3, 16'd0, 16'd1);
    // z stays at zero for c = 0, so that point never escapes; the other point does
    send_point(mk_point(32'sh0, 32'sh0));
    send_point(mk_point(32'sh0001_0000, 32'shFFFF_FFFF));
    wait_idle();
  endtask

  task automatic test_zero_limit();
    set_config(16'hF000, 16'd1000, 16'd4);
    send_point(mk_point(32'sh7FFF_FFFF, 32'sh8000_0000));
    send_point(mk_point(32'sh8000_0000, 32'sh7FFF_FFFF));
    wait_idle();
  endtask

  task automatic test_long_limit();
    // first point: |z|^2 sits exactly on the bailout from the second check on
    set_config(16'h0FFF, 16'd1, 16'd0);
    send_point(mk_point(32'sh0, 32'sh0));
    wait_idle();
    set_config(16'h0FFF, 16'hFFFF, 16'd8);
    write_reg(CfgUnused, 16'hFFFF);
    send_point(mk_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    wait_idle();
  endtask

  task automatic test_random_phases();
    int unsigned deg, eff, cost, iters, bail, r;
    logic [cet_pkg::CfgDataW-1:0] d;
    for (int ph = 0; ph < 8; ph++) begin
      deg = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      eff = (deg > MaxDegree) ? MaxDegree : deg;
      cost = (eff < 2) ? 16 : 17 + 31 * (eff - 1);
      // keep bounded points cheap on slow degrees
      iters = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 1200 / cost);
      r = $urandom_range(0, 9);
      bail = (r < 5) ? $urandom_range(1, 16) : (r < 8) ? $urandom_range(0, 255) :
             $urandom_range(0, 65535);
      d = cet_pkg::CfgDataW'($urandom);
      d[cet_pkg::IterW-1:0] = cet_pkg::IterW'(iters);
      write_reg(cet_pkg::CfgMaxIter, d);
      write_reg(cet_pkg::CfgBailout, cet_pkg::CfgDataW'(bail));
      d = cet_pkg::CfgDataW'($urandom);
      d[cet_pkg::DegCfgW-1:0] = cet_pkg::DegCfgW'(deg);
      write_reg(cet_pkg::CfgDegree, d);
      if ($urandom_range(0, 2) == 0) write_reg(CfgUnused, cet_pkg::CfgDataW'($urandom));
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PhaseItems; n++) send_point(rand_point());
      wait_idle();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_degree_sweep();
    test_zero_bailout();
    test_zero_limit();
    test_long_limit();
    test_random_phases();
    wait_idle();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/cet_pkg.sv
hw/rtl/cet_front.sv
hw/rtl/cet_fxmul.sv
hw/rtl/cet_back.sv
hw/rtl/chebyshev_escape_time_core.sv
bench/tb.sv
